// ----- hw/rtl/asg_pkg.sv -----
// Shared types, codes and limits of the assembler statement grouper.
// Used by asg_step and asm_statement_grouper_unit; no dependencies.
package asg_pkg;

  localparam int MaxOperands      = 8;
  localparam int MaxOperandTokens = 16;
  localparam int MaxLabels        = 4;
  localparam int DepthLimit       = 255;
  localparam int MaxRes           = 3;

  localparam int TypeW   = 5;
  localparam int TagW    = 16;
  localparam int LineW   = 16;
  localparam int DigitW  = 4;
  localparam int RoleW   = 4;
  localparam int OpIdxW  = 3;
  localparam int TokIdxW = 4;
  localparam int KindW   = 3;
  localparam int LabCntW = 3;
  localparam int PhaseW  = 3;
  localparam int LabCntMax = 7;

  localparam int OpcW    = $clog2(MaxOperands + 1);
  localparam int TioW    = $clog2(MaxOperandTokens + 1);
  localparam int LabW    = $clog2(MaxLabels + 1);
  localparam int DepW    = $clog2(DepthLimit + 1);
  localparam int ResCntW = $clog2(MaxRes + 1);
  localparam int ResIdxW = $clog2(MaxRes);

  localparam logic [TypeW-1:0] TkEof      = 5'd0;
  localparam logic [TypeW-1:0] TkNewline  = 5'd1;
  localparam logic [TypeW-1:0] TkSemi     = 5'd2;
  localparam logic [TypeW-1:0] TkComma    = 5'd3;
  localparam logic [TypeW-1:0] TkLparen   = 5'd4;
  localparam logic [TypeW-1:0] TkRparen   = 5'd5;
  localparam logic [TypeW-1:0] TkIdent    = 5'd6;
  localparam logic [TypeW-1:0] TkColon    = 5'd7;
  localparam logic [TypeW-1:0] TkLocalDef = 5'd8;
  localparam logic [TypeW-1:0] TkDotIdent = 5'd9;
  localparam logic [TypeW-1:0] TkDot      = 5'd10;
  localparam logic [TypeW-1:0] TkEquals   = 5'd11;
  localparam logic [TypeW-1:0] TkNumber   = 5'd12;
  localparam logic [TypeW-1:0] TkStar     = 5'd13;
  localparam logic [TypeW-1:0] TkHash     = 5'd14;
  localparam logic [TypeW-1:0] TkSlash    = 5'd15;
  localparam logic [TypeW-1:0] TkMinus    = 5'd16;
  localparam logic [TypeW-1:0] TkPlus     = 5'd17;
  localparam logic [TypeW-1:0] TkLocalRef = 5'd18;
  localparam logic [TypeW-1:0] TkOther    = 5'd19;

  localparam logic [RoleW-1:0] RoleSkipSep   = 4'd0;
  localparam logic [RoleW-1:0] RoleLabel     = 4'd1;
  localparam logic [RoleW-1:0] RoleColon     = 4'd2;
  localparam logic [RoleW-1:0] RoleLocalDef  = 4'd3;
  localparam logic [RoleW-1:0] RoleDirective = 4'd4;
  localparam logic [RoleW-1:0] RoleMnemonic  = 4'd5;
  localparam logic [RoleW-1:0] RoleAssignTgt = 4'd6;
  localparam logic [RoleW-1:0] RoleEquals    = 4'd7;
  localparam logic [RoleW-1:0] RoleOperand   = 4'd8;
  localparam logic [RoleW-1:0] RoleComma     = 4'd9;
  localparam logic [RoleW-1:0] RoleErrSkip   = 4'd10;
  localparam logic [RoleW-1:0] RoleStmtEnd   = 4'd11;
  localparam logic [RoleW-1:0] RoleEndInput  = 4'd12;

  localparam logic [KindW-1:0] KindEmpty  = 3'd0;
  localparam logic [KindW-1:0] KindLabel  = 3'd1;
  localparam logic [KindW-1:0] KindDir    = 3'd2;
  localparam logic [KindW-1:0] KindAssign = 3'd3;
  localparam logic [KindW-1:0] KindInstr  = 3'd4;
  localparam logic [KindW-1:0] KindData   = 3'd5;

  localparam logic [PhaseW-1:0] PhStart  = 3'd0;
  localparam logic [PhaseW-1:0] PhLabels = 3'd1;
  localparam logic [PhaseW-1:0] PhList   = 3'd2;
  localparam logic [PhaseW-1:0] PhSingle = 3'd3;
  localparam logic [PhaseW-1:0] PhSkip   = 3'd4;

  typedef struct packed {
    logic [TypeW-1:0]  token_type;
    logic [TagW-1:0]   token_tag;
    logic [LineW-1:0]  token_line;
    logic [DigitW-1:0] token_digit;
  } token_t;

  typedef struct packed {
    logic [TagW-1:0]    tag_out;
    logic [RoleW-1:0]   role;
    logic [OpIdxW-1:0]  operand_index;
    logic [TokIdxW-1:0] token_index;
    logic               dropped;
    logic [KindW-1:0]   stmt_kind;
    logic [LineW-1:0]   stmt_line;
    logic [LabCntW-1:0] label_count;
    logic [DigitW-1:0]  local_digit_out;
    logic               has_local_def;
    logic               bad_start;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              held_vld;
    logic              held_dot;
    logic [TagW-1:0]   held_tag;
    logic [DepW-1:0]   depth;
    logic [OpcW-1:0]   opc;
    logic [TioW-1:0]   tio;
    logic [LabW-1:0]   labels;
    logic [KindW-1:0]  kind;
    logic [LineW-1:0]  line;
    logic              local_vld;
    logic [DigitW-1:0] lbl_digit;
  } asg_state_t;

  localparam asg_state_t RstState = '{phase: PhStart, default: '0};

endpackage

// ----- hw/rtl/asg_step.sv -----
// Next-state and result logic of the statement grouper for one token.
// Depends on asg_pkg.
module asg_step import asg_pkg::*; (
  input  asg_state_t                st_i,
  input  token_t                    tok_i,
  output asg_state_t                st_o,
  output result_t [MaxRes-1:0]      res_o,
  output logic    [ResCntW-1:0]     cnt_o
);

  function automatic result_t mk(logic [TagW-1:0] tag, logic [RoleW-1:0] role,
                                 logic [OpIdxW-1:0] opi, logic [TokIdxW-1:0] toki,
                                 logic drop);
    result_t r;
    r = '0;
    r.tag_out       = tag;
    r.role          = role;
    r.operand_index = opi;
    r.token_index   = toki;
    r.dropped       = drop;
    return r;
  endfunction

  function automatic result_t op_res(asg_state_t s, logic [TagW-1:0] tag);
    result_t r;
    if (s.opc >= OpcW'(MaxOperands) || s.tio >= TioW'(MaxOperandTokens)) begin
      r = mk(tag, RoleOperand, '0, '0, 1'b1);
    end else begin
      r = mk(tag, RoleOperand, OpIdxW'(s.opc), TokIdxW'(s.tio), 1'b0);
    end
    return r;
  endfunction

  function automatic asg_state_t op_next(asg_state_t s, logic [TypeW-1:0] ty);
    asg_state_t n;
    n = s;
    if (ty == TkLparen && s.depth < DepW'(DepthLimit)) n.depth = s.depth + 1'b1;
    if (ty == TkRparen && s.depth != '0) n.depth = s.depth - 1'b1;
    if (s.tio < TioW'(MaxOperandTokens)) n.tio = s.tio + 1'b1;
    return n;
  endfunction

  function automatic result_t end_res(asg_state_t s, logic [TagW-1:0] tag);
    result_t r;
    r = mk(tag, RoleStmtEnd, '0, '0, 1'b0);
    r.stmt_kind       = s.kind;
    r.stmt_line       = s.line;
    r.label_count     = (s.labels > LabW'(LabCntMax)) ? LabCntW'(LabCntMax)
                                                      : LabCntW'(s.labels);
    r.local_digit_out = s.lbl_digit;
    r.has_local_def   = s.local_vld;
    r.bad_start       = (s.phase == PhSkip);
    return r;
  endfunction

  always_comb begin
    asg_state_t          s;
    logic [ResCntW-1:0]  n;
    logic [TypeW-1:0]    ty;
    logic                colon_lbl;
    logic                assign_tgt;
    s     = st_i;
    n     = '0;
    res_o = '0;
    ty    = (tok_i.token_type > TkOther) ? TkOther : tok_i.token_type;
    colon_lbl  = s.held_vld && !s.held_dot && ty == TkColon;
    assign_tgt = s.held_vld && ty == TkEquals;

    // resolve a held identifier or dot that is not a label or assignment target
    if (s.held_vld && !colon_lbl && !assign_tgt) begin
      s.held_vld = 1'b0;
      if (s.held_dot) begin
        s.kind  = KindData;
        s.phase = PhSingle;
        res_o[n[ResIdxW-1:0]] = op_res(s, s.held_tag);
        n = n + 1'b1;
        s = op_next(s, TkDot);
      end else begin
        s.kind  = KindInstr;
        s.phase = PhList;
        res_o[n[ResIdxW-1:0]] = mk(s.held_tag, RoleMnemonic, '0, '0, 1'b0);
        n = n + 1'b1;
      end
    end

    if (ty <= TkSemi) begin
      if (s.phase != PhStart) begin
        if (s.phase == PhLabels) s.kind = (s.labels != '0) ? KindLabel : KindEmpty;
        res_o[n[ResIdxW-1:0]] = end_res(s, tok_i.token_tag);
        n = n + 1'b1;
        s = RstState;
      end
      res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, (ty == TkEof) ? RoleEndInput : RoleSkipSep,
                                 '0, '0, 1'b0);
      n = n + 1'b1;
      s.phase = PhStart;
    end else if (colon_lbl) begin
      s.held_vld = 1'b0;
      if (s.labels < LabW'(MaxLabels)) begin
        s.labels = s.labels + 1'b1;
        res_o[n[ResIdxW-1:0]] = mk(s.held_tag, RoleLabel, '0, '0, 1'b0);
      end else begin
        res_o[n[ResIdxW-1:0]] = mk(s.held_tag, RoleLabel, '0, '0, 1'b1);
      end
      n = n + 1'b1;
      res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleColon, '0, '0, 1'b0);
      n = n + 1'b1;
    end else if (assign_tgt) begin
      s.held_vld = 1'b0;
      s.kind     = KindAssign;
      s.phase    = PhSingle;
      res_o[n[ResIdxW-1:0]] = mk(s.held_tag, RoleAssignTgt, '0, '0, 1'b0);
      n = n + 1'b1;
      res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleEquals, '0, '0, 1'b0);
      n = n + 1'b1;
    end else begin
      // close a single-operand statement at a top-level comma
      if (s.phase == PhSingle && ty == TkComma && s.depth == '0) begin
        res_o[n[ResIdxW-1:0]] = end_res(s, tok_i.token_tag);
        n = n + 1'b1;
        s = RstState;
      end
      case (s.phase)
        PhStart, PhLabels: begin
          if (s.phase == PhStart) begin
            s.line  = tok_i.token_line;
            s.phase = PhLabels;
          end
          if (ty == TkLocalDef) begin
            if (s.labels < LabW'(MaxLabels)) begin
              s.labels = s.labels + 1'b1;
              res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleLocalDef, '0, '0, 1'b0);
            end else begin
              res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleLocalDef, '0, '0, 1'b1);
            end
            n = n + 1'b1;
            s.local_vld = 1'b1;
            s.lbl_digit = tok_i.token_digit;
          end else if (ty == TkIdent || ty == TkDot) begin
            s.held_vld = 1'b1;
            s.held_dot = (ty == TkDot);
            s.held_tag = tok_i.token_tag;
          end else if (ty == TkDotIdent) begin
            s.kind  = KindDir;
            s.phase = PhList;
            res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleDirective, '0, '0, 1'b0);
            n = n + 1'b1;
          end else if (ty inside {TkNumber, TkDot, TkStar, TkHash, TkSlash, TkMinus,
                                  TkPlus, TkLocalRef, TkLparen}) begin
            s.kind  = KindData;
            s.phase = PhSingle;
            res_o[n[ResIdxW-1:0]] = op_res(s, tok_i.token_tag);
            n = n + 1'b1;
            s = op_next(s, ty);
          end else begin
            s.kind  = KindEmpty;
            s.phase = PhSkip;
            res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleErrSkip, '0, '0, 1'b0);
            n = n + 1'b1;
          end
        end
        PhList: begin
          if (ty == TkComma && s.depth == '0) begin
            if (s.opc >= OpcW'(MaxOperands)) begin
              res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleComma, '0, '0, 1'b1);
            end else begin
              res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleComma, OpIdxW'(s.opc),
                                         '0, 1'b0);
              s.opc = s.opc + 1'b1;
            end
            n = n + 1'b1;
            s.tio   = '0;
            s.depth = '0;
          end else begin
            res_o[n[ResIdxW-1:0]] = op_res(s, tok_i.token_tag);
            n = n + 1'b1;
            s = op_next(s, ty);
          end
        end
        PhSingle: begin
          res_o[n[ResIdxW-1:0]] = op_res(s, tok_i.token_tag);
          n = n + 1'b1;
          s = op_next(s, ty);
        end
        default: begin
          res_o[n[ResIdxW-1:0]] = mk(tok_i.token_tag, RoleErrSkip, '0, '0, 1'b0);
          n = n + 1'b1;
        end
      endcase
    end

    if (n != '0) res_o[ResIdxW'(n - 1'b1)].last = 1'b1;
    st_o  = s;
    cnt_o = n;
  end

endmodule

// ----- hw/rtl/asm_statement_grouper_unit.sv -----
// Top level of the assembler statement grouper: token register, state, result group.
// Depends on asg_pkg and asg_step.
//
//   port group   dir  handshake                 payload
//   in_*         in   in_valid_i / in_stall_o   token_t  in_req_i
//   out_*        out  out_valid_o / out_stall_i result_t out_req_o
//
// A token is registered on accept and, once the result group is free, resolved
// into a group of zero to three results, shown one result per cycle unless the
// output stalls. Tokens with one result each flow at one per cycle without output
// stalls; a token with more results holds the result group until its last is taken.
// Reset clears the statement state and empties both registers.
// An output stall holds the shown result and, once the token register is full, stalls input.
module asm_statement_grouper_unit import asg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  token_t  in_req_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_req_o
);

  logic                        tok_vld_q, tok_vld_d;
  token_t                      tok_q;
  asg_state_t                  st_q, st_d;
  result_t [MaxRes-1:0]        res_q, res_d;
  logic    [ResCntW-1:0]       cnt_q, cnt_d, cnt_n;
  logic    [ResIdxW-1:0]       rd_q, rd_d;
  logic                        in_acc, pop, rd_last, grp_free, advance;

  asg_step u_step (
    .st_i  (st_q),
    .tok_i (tok_q),
    .st_o  (st_d),
    .res_o (res_d),
    .cnt_o (cnt_n)
  );

  assign out_valid_o = (cnt_q != '0);
  assign out_req_o   = res_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign rd_last     = (ResCntW'(rd_q) == cnt_q - 1'b1);
  assign grp_free    = !out_valid_o || (pop && rd_last);
  assign advance     = tok_vld_q && grp_free;
  assign in_stall_o  = tok_vld_q && !advance;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign tok_vld_d   = in_acc || (tok_vld_q && !advance);

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (advance) begin
      cnt_d = cnt_n;
      rd_d  = '0;
    end else if (pop && rd_last) begin
      cnt_d = '0;
      rd_d  = '0;
    end else if (pop) begin
      rd_d = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      st_q      <= RstState;
      cnt_q     <= '0;
      rd_q      <= '0;
    end else begin
      tok_vld_q <= tok_vld_d;
      if (advance) st_q <= st_d;
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) tok_q <= in_req_i;
    if (advance) res_q <= res_d;
  end

  a_rd_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ResCntW'(rd_q) < cnt_q))
    else $error("result read pointer beyond group");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last == rd_last))
    else $error("last flag does not match end of result group");

  a_stall_needs_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (tok_vld_q && out_valid_o))
    else $error("input stalled with free token register or empty group");

endmodule
